/* rtl/erd_pkg.sv */
// Shared types, codes and result builders for the event record stream decoder.
package erd_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [10:0] {
        PH_MAGIC    = 11'b000_0000_0001,
        PH_VERSION  = 11'b000_0000_0010,
        PH_RESERVED = 11'b000_0000_0100,
        PH_NAMELEN  = 11'b000_0000_1000,
        PH_NAME     = 11'b000_0001_0000,
        PH_TOTAL    = 11'b000_0010_0000,
        PH_COUNT    = 11'b000_0100_0000,
        PH_DELTA    = 11'b000_1000_0000,
        PH_BUTTON   = 11'b001_0000_0000,
        PH_FLAGS    = 11'b010_0000_0000,
        PH_DONE     = 11'b100_0000_0000
    } t_phase;

    typedef enum logic {
        REG_MAGIC   = 1'b0,
        REG_VERSION = 1'b1
    } t_reg_index;

    localparam logic [1:0] KIND_EVENT  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_TRUNCATED   = 2'd0;
    localparam logic [1:0] ERR_BAD_MAGIC   = 2'd1;
    localparam logic [1:0] ERR_BAD_VERSION = 2'd2;
    localparam logic [1:0] ERR_OVERLONG    = 2'd3;

    localparam logic [4:0] VARINT_STEP      = 5'd7;
    localparam logic [4:0] VARINT_LAST_SHIFT = 5'd28;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] frame;
        logic [7:0]  button;
        logic        pressed;
        logic        second_player;
        logic [31:0] total_frames;
        logic [1:0]  error_code;
        logic        final_result;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic        we;
        t_reg_index  index;
        logic [31:0] data;
    } t_cfg_wr;

    function automatic t_result make_error(input logic [1:0] code);
        t_result r;
        r = '0;
        r.kind         = KIND_ERROR;
        r.error_code   = code;
        r.final_result = 1'b1;
        return r;
    endfunction

    function automatic t_result make_finish(input logic [31:0] total);
        t_result r;
        r = '0;
        r.kind         = KIND_FINISH;
        r.total_frames = total;
        r.final_result = 1'b1;
        return r;
    endfunction

    function automatic t_result make_event(input logic [31:0] frame,
                                           input logic [7:0]  button,
                                           input logic [7:0]  flags);
        t_result r;
        r = '0;
        r.kind          = KIND_EVENT;
        r.frame         = frame;
        r.button        = button;
        r.pressed       = flags[0];
        r.second_player = flags[1];
        return r;
    endfunction

endpackage

/* rtl/event_record_stream_decoder.sv */
// Top level of the event record stream decoder: parser and result queue.
//
// Input channel: one buffer byte per transfer (i_in_valid, o_in_stall), with
// i_end_of_buffer marking the final byte. The block checks magic and version,
// skips the reserved halfword and the name, reads the total frame count and
// event count, then turns each delta/button/flags triple into an event result.
// Output channel: one result per transfer (o_out_valid, i_out_stall): event,
// finish or error; finish or the first error comes once per buffer.
// With the queue empty, a byte's first result is offered the cycle after its
// transfer; a second result from the same byte follows once the first is taken.
// Throughput: one byte per cycle unless o_in_stall is raised; the parser state
// update is a single pass from the state registers into a four-entry result queue.
// The input stalls whenever fewer than two queue slots are free, so a stalled
// receiver backs up into the byte stream without losing results.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data write magic (index 0) or
// version (index 1); the user must do so only while the block is idle, which the block does not enforce.
// Reset (synchronous, active low) empties the queue, sets magic to 0, version
// to 1 and puts the parser at the start of a buffer.
module event_record_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_frame,
    output logic [7:0]  o_button,
    output logic        o_pressed,
    output logic        o_second_player,
    output logic [31:0] o_total_frames,
    output logic [1:0]  o_error_code,
    output logic        o_final_result
);

    erd_pkg::t_cfg_wr  cfg;
    erd_pkg::t_push    push;
    erd_pkg::t_result  result;
    logic              room;
    logic              take;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = erd_pkg::t_reg_index'(i_cfg_index);
    assign cfg.data  = i_cfg_data;

    assign o_in_stall = !room;
    assign take       = i_in_valid && room;

    erd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_take  (take),
        .i_byte  (i_data_byte),
        .i_last  (i_end_of_buffer),
        .o_push  (push)
    );

    erd_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (result)
    );

    assign o_kind          = result.kind;
    assign o_frame         = result.frame;
    assign o_button        = result.button;
    assign o_pressed       = result.pressed;
    assign o_second_player = result.second_player;
    assign o_total_frames  = result.total_frames;
    assign o_error_code    = result.error_code;
    assign o_final_result  = result.final_result;

endmodule

/* rtl/erd_parser.sv */
// Byte-wise header and event parser: state registers and result formation.
module erd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  erd_pkg::t_cfg_wr i_cfg,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output erd_pkg::t_push  o_push
);

    logic [31:0]     r_magic;
    logic [15:0]     r_version;

    erd_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_pos, n_pos;
    logic [4:0]      r_shift, n_shift;
    logic [31:0]     r_skip, n_skip;
    logic [31:0]     r_total, n_total;
    logic [31:0]     r_events, n_events;
    logic [31:0]     r_prev, n_prev;
    logic [31:0]     r_acc, n_acc;
    logic [7:0]      r_button, n_button;
    logic            r_ovf, n_ovf;

    logic [31:0]     acc_or;
    logic [31:0]     frame_sum;
    erd_pkg::t_push  push;

    // little-endian field assembly, byte lane chosen by position
    assign acc_or    = r_acc | ({24'd0, i_byte} << {r_pos[1:0], 3'd0});
    assign frame_sum = r_prev + r_acc;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_skip   = r_skip;
        n_total  = r_total;
        n_events = r_events;
        n_prev   = r_prev;
        n_acc    = r_acc;
        n_button = r_button;
        n_ovf    = r_ovf;
        push     = '0;

        unique case (r_phase)
            erd_pkg::PH_MAGIC: begin
                n_acc = acc_or;
                n_pos = r_pos + 3'd1;
                if (r_pos == 3'd3) begin
                    n_pos = 3'd0;
                    if (acc_or != r_magic) begin
                        push.first = erd_pkg::make_error(erd_pkg::ERR_BAD_MAGIC);
                        push.count = 2'd1;
                        n_phase    = erd_pkg::PH_DONE;
                    end else begin
                        n_acc   = '0;
                        n_phase = erd_pkg::PH_VERSION;
                    end
                end
            end
            erd_pkg::PH_VERSION: begin
                n_acc = acc_or;
                n_pos = r_pos + 3'd1;
                if (r_pos == 3'd1) begin
                    n_pos   = 3'd0;
                    n_total = acc_or; // held until the reserved halfword is in
                    n_acc   = '0;
                    n_phase = erd_pkg::PH_RESERVED;
                end
            end
            erd_pkg::PH_RESERVED: begin
                n_acc = acc_or;
                n_pos = r_pos + 3'd1;
                if (r_pos == 3'd1) begin
                    n_pos = 3'd0;
                    n_acc = '0;
                    if (r_total != {16'd0, r_version}) begin
                        push.first = erd_pkg::make_error(erd_pkg::ERR_BAD_VERSION);
                        push.count = 2'd1;
                        n_phase    = erd_pkg::PH_DONE;
                    end else begin
                        n_total = '0;
                        n_phase = erd_pkg::PH_NAMELEN;
                    end
                end
            end
            erd_pkg::PH_NAMELEN: begin
                n_acc = acc_or;
                n_pos = r_pos + 3'd1;
                if (r_pos == 3'd3) begin
                    n_pos   = 3'd0;
                    n_skip  = acc_or;
                    n_acc   = '0;
                    n_phase = (acc_or != '0) ? erd_pkg::PH_NAME : erd_pkg::PH_TOTAL;
                end
            end
            erd_pkg::PH_NAME: begin
                n_skip = r_skip - 32'd1;
                if (r_skip == 32'd1) begin
                    n_phase = erd_pkg::PH_TOTAL;
                end
            end
            erd_pkg::PH_TOTAL: begin
                n_acc = acc_or;
                n_pos = r_pos + 3'd1;
                if (r_pos == 3'd3) begin
                    n_pos   = 3'd0;
                    n_total = acc_or;
                    n_acc   = '0;
                    n_phase = erd_pkg::PH_COUNT;
                end
            end
            erd_pkg::PH_COUNT: begin
                n_acc = acc_or;
                n_pos = r_pos + 3'd1;
                if (r_pos == 3'd3) begin
                    n_pos    = 3'd0;
                    n_events = acc_or;
                    n_acc    = '0;
                    n_shift  = '0;
                    n_ovf    = 1'b0;
                    if (acc_or == '0) begin
                        push.first = erd_pkg::make_finish(r_total);
                        push.count = 2'd1;
                        n_phase    = erd_pkg::PH_DONE;
                    end else begin
                        n_phase = erd_pkg::PH_DELTA;
                    end
                end
            end
            erd_pkg::PH_DELTA: begin
                if (r_ovf) begin
                    push.first = erd_pkg::make_error(erd_pkg::ERR_OVERLONG);
                    push.count = 2'd1;
                    n_phase    = erd_pkg::PH_DONE;
                end else begin
                    // bits above 31 of the fifth byte fall off the top
                    n_acc = r_acc | ({25'd0, i_byte[6:0]} << r_shift);
                    if (i_byte[7]) begin
                        if (r_shift >= erd_pkg::VARINT_LAST_SHIFT) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_shift = r_shift + erd_pkg::VARINT_STEP;
                        end
                    end else begin
                        n_phase = erd_pkg::PH_BUTTON;
                    end
                end
            end
            erd_pkg::PH_BUTTON: begin
                n_button = i_byte;
                n_phase  = erd_pkg::PH_FLAGS;
            end
            erd_pkg::PH_FLAGS: begin
                push.first = erd_pkg::make_event(frame_sum, r_button, i_byte);
                push.count = 2'd1;
                n_prev     = frame_sum;
                n_acc      = '0;
                n_shift    = '0;
                n_ovf      = 1'b0;
                n_events   = r_events - 32'd1;
                if (r_events == 32'd1) begin
                    push.second = erd_pkg::make_finish(r_total);
                    push.count  = 2'd2;
                    n_phase     = erd_pkg::PH_DONE;
                end else begin
                    n_phase = erd_pkg::PH_DELTA;
                end
            end
            erd_pkg::PH_DONE: begin
                // trailing bytes up to the end mark are dropped
            end
            default: begin
                n_phase = erd_pkg::PH_DONE;
            end
        endcase

        if (i_last) begin
            if (n_phase != erd_pkg::PH_DONE) begin
                if (push.count == 2'd0) begin
                    push.first = erd_pkg::make_error(erd_pkg::ERR_TRUNCATED);
                end else begin
                    push.second = erd_pkg::make_error(erd_pkg::ERR_TRUNCATED);
                end
                push.count = push.count + 2'd1;
            end
            n_phase  = erd_pkg::PH_MAGIC;
            n_pos    = '0;
            n_shift  = '0;
            n_skip   = '0;
            n_total  = '0;
            n_events = '0;
            n_prev   = '0;
            n_acc    = '0;
            n_button = '0;
            n_ovf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_version <= 16'd1;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                erd_pkg::REG_MAGIC:   r_magic   <= i_cfg.data;
                erd_pkg::REG_VERSION: r_version <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= erd_pkg::PH_MAGIC;
            r_pos    <= '0;
            r_shift  <= '0;
            r_skip   <= '0;
            r_total  <= '0;
            r_events <= '0;
            r_prev   <= '0;
            r_acc    <= '0;
            r_button <= '0;
            r_ovf    <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_skip   <= n_skip;
            r_total  <= n_total;
            r_events <= n_events;
            r_prev   <= n_prev;
            r_acc    <= n_acc;
            r_button <= n_button;
            r_ovf    <= n_ovf;
        end
    end

    always_comb begin
        o_push = push;
        if (!i_take) begin
            o_push.count = 2'd0;
        end
    end

endmodule

/* rtl/erd_result_fifo.sv */
// Small result queue: takes up to two results a cycle, hands out one unless stalled.
module erd_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  erd_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_stall,
    output erd_pkg::t_result o_data
);

    erd_pkg::t_result                r_mem [erd_pkg::FIFO_DEPTH];
    logic [erd_pkg::PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [erd_pkg::PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [erd_pkg::CNT_W-1:0]       r_count, n_count;
    logic                            pop;
    logic [erd_pkg::PTR_W-1:0]       wr_ptr_next;

    assign o_valid     = (r_count != '0);
    assign o_data      = r_mem[r_rd_ptr];
    assign pop         = o_valid && !i_stall;
    // two free slots needed: one byte can raise two results
    assign o_room      = (r_count <= erd_pkg::CNT_W'(erd_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_next = r_wr_ptr + erd_pkg::PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + erd_pkg::PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + erd_pkg::PTR_W'(pop);
        n_count  = r_count + erd_pkg::CNT_W'(i_push.count) - erd_pkg::CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < erd_pkg::FIFO_DEPTH; i++) begin
            if (i_push.count != 2'd0 && erd_pkg::PTR_W'(i) == r_wr_ptr) begin
                r_mem[i] <= i_push.first;
            end else if (i_push.count == 2'd2 && erd_pkg::PTR_W'(i) == wr_ptr_next) begin
                r_mem[i] <= i_push.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
